// ===== sv/rlptx_pkg.sv =====
package rlptx_pkg;

    localparam int HEADER_MAX_BYTES_DEF = 5;
    localparam int INT_MAX_BYTES_DEF    = 32;
    localparam int ADDR_MAX_BYTES_DEF   = 20;
    localparam int SHARD_MAX_BYTES_DEF  = 4;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 3;

    // header byte boundaries
    localparam logic [7:0] HDR_SELF_MAX  = 8'h7f;
    localparam logic [7:0] HDR_STR_BASE  = 8'h80;
    localparam logic [7:0] HDR_SSTR_MAX  = 8'hb7;
    localparam logic [7:0] HDR_LSTR_MAX  = 8'hbf;
    localparam logic [7:0] HDR_LIST_BASE = 8'hc0;
    localparam logic [7:0] HDR_SLIST_MAX = 8'hf7;
    localparam logic [3:0] LEN_BYTES_MAX = 4'd4;

    localparam logic [3:0] FLD_ENVELOPE  = 4'd0;
    localparam logic [3:0] FLD_FROMSHARD = 4'd4;
    localparam logic [3:0] FLD_TOSHARD   = 4'd5;
    localparam logic [3:0] FLD_DEST      = 4'd6;
    localparam logic [3:0] FLD_AMOUNT    = 4'd7;
    localparam logic [3:0] FLD_END       = 4'd8;

    typedef enum logic [1:0] {
        ST_MORE = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

endpackage

// ===== sv/rlp_transaction_field_parser.sv =====
// Each input transfer's result is registered onto the master side in the cycle after the transfer.
// Throughput: one byte per cycle; the parse state updates in a single pass
// of header/limit compares and feeds back into the next byte's pass.
// The output register frees as its result is taken, so input stalls only
// while a result waits unaccepted.
// Reset (rst_n low, asynchronous): parser returns to envelope-expected, no error.
module rlp_transaction_field_parser #(
    parameter int HEADER_MAX_BYTES = rlptx_pkg::HEADER_MAX_BYTES_DEF,
    parameter int INT_MAX_BYTES    = rlptx_pkg::INT_MAX_BYTES_DEF,
    parameter int ADDR_MAX_BYTES   = rlptx_pkg::ADDR_MAX_BYTES_DEF,
    parameter int SHARD_MAX_BYTES  = rlptx_pkg::SHARD_MAX_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rlptx_pkg::IN_DATA_W-1:0]  s_tdata,  // data_byte[7:0]
    input  logic [rlptx_pkg::IN_USER_W-1:0]  s_tuser,  // start_tx[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // payload_valid[0], payload_byte[8:1], payload_pos[13:9], field_done[14],
    // field_length[46:15], shard_value[78:47], status[80:79], zero[87:81]
    output logic [rlptx_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [rlptx_pkg::OUT_USER_W-1:0] m_tuser   // field_id[2:0]
);
    import rlptx_pkg::*;

    localparam int CNT_W   = $clog2(HEADER_MAX_BYTES + 1);
    localparam int LIM_A   = (INT_MAX_BYTES > ADDR_MAX_BYTES) ? INT_MAX_BYTES : ADDR_MAX_BYTES;
    localparam int MAX_LIM = (LIM_A > SHARD_MAX_BYTES) ? LIM_A : SHARD_MAX_BYTES;
    localparam int LEN_W   = $clog2(MAX_LIM + 1);

    logic             err_reg, err_next;
    logic [3:0]       fidx_reg, fidx_next;
    logic             in_field_reg, in_field_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       b0_reg, b0_next;
    logic [31:0]      len_acc_reg, len_acc_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;
    logic [LEN_W-1:0] cur_pos_reg, cur_pos_next;
    logic [31:0]      shard_reg, shard_next;

    logic             out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;

    logic accept;
    logic [7:0] in_byte;
    logic start;

    // state as seen by this byte, after an optional start-of-transaction clear
    logic             e_err, e_in_field;
    logic [3:0]       e_fidx;
    logic [CNT_W-1:0] e_cnt;

    logic        fail, do_field, pl;
    logic [7:0]  hb0;
    logic [3:0]  nlen, need;
    logic [4:0]  cnt_inc;
    logic [31:0] hlen, flen, limit;
    logic        is_list, self_enc;
    logic [LEN_W-1:0] base_pos, pos_new;
    logic [31:0] shard_new;

    logic        o_pv, o_done;
    logic [7:0]  o_byte;
    logic [4:0]  o_pos;
    logic [31:0] o_len, o_shard;
    status_t     o_st;
    logic [2:0]  o_fid;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_byte  = s_tdata[7:0];
    assign start    = s_tuser[0];

    assign e_err      = start ? 1'b0 : err_reg;
    assign e_fidx     = start ? FLD_ENVELOPE : fidx_reg;
    assign e_in_field = start ? 1'b0 : in_field_reg;
    assign e_cnt      = start ? '0 : cnt_reg;

    always_comb
    begin
        if (e_fidx == FLD_FROMSHARD || e_fidx == FLD_TOSHARD)
            limit = 32'(SHARD_MAX_BYTES);
        else if (e_fidx == FLD_DEST)
            limit = 32'(ADDR_MAX_BYTES);
        else
            limit = 32'(INT_MAX_BYTES);
    end

    always_comb
    begin
        err_next      = e_err;
        fidx_next     = e_fidx;
        in_field_next = e_in_field;
        cnt_next      = e_cnt;
        b0_next       = b0_reg;
        len_acc_next  = len_acc_reg;
        cur_len_next  = cur_len_reg;
        cur_pos_next  = cur_pos_reg;
        shard_next    = shard_reg;

        fail      = 1'b0;
        do_field  = 1'b0;
        pl        = 1'b0;
        hb0       = (e_cnt == '0) ? in_byte : b0_reg;
        nlen      = 4'd0;
        need      = 4'd1;
        cnt_inc   = 5'(e_cnt) + 5'd1;
        hlen      = 32'd0;
        flen      = 32'(cur_len_reg);
        is_list   = 1'b0;
        self_enc  = 1'b0;
        base_pos  = cur_pos_reg;
        pos_new   = cur_pos_reg;
        shard_new = shard_reg;

        o_fid   = (e_fidx > FLD_AMOUNT) ? FLD_AMOUNT[2:0] : e_fidx[2:0];
        o_pv    = 1'b0;
        o_byte  = 8'd0;
        o_pos   = 5'd0;
        o_done  = 1'b0;
        o_len   = 32'd0;
        o_shard = 32'd0;
        o_st    = ST_MORE;

        if (e_err) begin
            o_st = ST_ERR;
        end else if (e_fidx >= FLD_END) begin
            o_st = ST_DONE;
        end else if (!e_in_field) begin
            // long forms: low three bits of the header give length-of-length minus one
            if ((hb0 > HDR_SSTR_MAX && hb0 <= HDR_LSTR_MAX) || hb0 > HDR_SLIST_MAX)
                nlen = {1'b0, hb0[2:0]} + 4'd1;
            need         = nlen + 4'd1;
            b0_next      = hb0;
            len_acc_next = (e_cnt == '0) ? 32'd0 : {len_acc_reg[23:0], in_byte};
            cnt_next     = CNT_W'(cnt_inc);

            if (cnt_inc < {1'b0, need}) begin
                if (cnt_inc >= 5'(HEADER_MAX_BYTES))
                    fail = 1'b1;
            end else if (nlen > LEN_BYTES_MAX) begin
                fail = 1'b1;
            end else begin
                if (hb0 <= HDR_SELF_MAX) begin
                    hlen     = 32'd1;
                    self_enc = 1'b1;
                end else if (hb0 <= HDR_SSTR_MAX) begin
                    hlen = 32'(hb0 - HDR_STR_BASE);
                end else if (hb0 <= HDR_LSTR_MAX) begin
                    hlen = len_acc_next;
                end else if (hb0 <= HDR_SLIST_MAX) begin
                    hlen    = 32'(hb0 - HDR_LIST_BASE);
                    is_list = 1'b1;
                end else begin
                    hlen    = len_acc_next;
                    is_list = 1'b1;
                end
                cnt_next = '0;

                if (e_fidx == FLD_ENVELOPE) begin
                    if (!is_list) begin
                        fail = 1'b1;
                    end else begin
                        o_done        = 1'b1;
                        o_len         = hlen;
                        fidx_next     = e_fidx + 4'd1;
                        in_field_next = 1'b0;
                    end
                end else if (is_list || hlen > limit) begin
                    fail = 1'b1;
                end else begin
                    do_field     = 1'b1;
                    pl           = self_enc;
                    base_pos     = '0;
                    shard_new    = 32'd0;
                    flen         = hlen;
                    cur_len_next = LEN_W'(hlen);
                end
            end
        end else begin
            do_field = 1'b1;
            pl       = 1'b1;
        end

        if (do_field) begin
            pos_new = base_pos;
            if (pl) begin
                o_pv      = 1'b1;
                o_byte    = in_byte;
                o_pos     = 5'(base_pos);
                shard_new = {shard_new[23:0], in_byte};
                pos_new   = base_pos + LEN_W'(1);
            end
            cur_pos_next  = pos_new;
            shard_next    = shard_new;
            o_len         = flen;
            in_field_next = 1'b1;
            if (32'(pos_new) >= flen) begin
                o_done = 1'b1;
                if (e_fidx == FLD_FROMSHARD || e_fidx == FLD_TOSHARD)
                    o_shard = shard_new;
                fidx_next     = e_fidx + 4'd1;
                in_field_next = 1'b0;
                if (e_fidx + 4'd1 >= FLD_END)
                    o_st = ST_DONE;
            end
        end

        if (fail) begin
            err_next      = 1'b1;
            in_field_next = 1'b0;
            cnt_next      = '0;
            o_pv          = 1'b0;
            o_byte        = 8'd0;
            o_pos         = 5'd0;
            o_done        = 1'b0;
            o_len         = 32'd0;
            o_shard       = 32'd0;
            o_st          = ST_ERR;
        end

        out_data_next = {7'd0, o_st, o_shard, o_len, o_done, o_pos, o_byte, o_pv};
        out_user_next = o_fid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            err_reg       <= 1'b0;
            fidx_reg      <= FLD_ENVELOPE;
            in_field_reg  <= 1'b0;
            cnt_reg       <= '0;
            cur_len_reg   <= '0;
            cur_pos_reg   <= '0;
            shard_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                err_reg      <= err_next;
                fidx_reg     <= fidx_next;
                in_field_reg <= in_field_next;
                cnt_reg      <= cnt_next;
                cur_len_reg  <= cur_len_next;
                cur_pos_reg  <= cur_pos_next;
                shard_reg    <= shard_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // header scratch and result payload carry no reset
    always_ff @(posedge clk)
    begin
        if (accept) begin
            b0_reg       <= b0_next;
            len_acc_reg  <= len_acc_next;
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        accept && err_reg && !start |=> m_tvalid && m_tdata[80:79] == ST_ERR)
        else $error("error status not held");

    a_start_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && start |=> m_tvalid && m_tdata[80:79] != ST_DONE)
        else $error("transaction done on its first byte");

    a_in_field_ok: assert property (@(posedge clk) disable iff (!rst_n)
        in_field_reg |-> !err_reg && fidx_reg != FLD_ENVELOPE && fidx_reg < FLD_END)
        else $error("payload state outside a string field");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_field_reg |-> cur_pos_reg < cur_len_reg)
        else $error("payload position past field length");

    a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) < 32'(HEADER_MAX_BYTES) && !(in_field_reg && cnt_reg != '0))
        else $error("header count out of range");
`endif

endmodule

// ===== test/rlp_field_checker.sv =====
module rlp_field_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [rlptx_pkg::IN_DATA_W-1:0]   s_tdata,   // data_byte[7:0]
    input  logic [rlptx_pkg::IN_USER_W-1:0]   s_tuser,   // start_tx[0]
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // payload_valid[0], payload_byte[8:1], payload_pos[13:9], field_done[14],
    // field_length[46:15], shard_value[78:47], status[80:79], zero[87:81]
    input  logic [rlptx_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [rlptx_pkg::OUT_USER_W-1:0]  m_tuser,   // field_id[2:0]
    output int                                mismatches,
    output int                                pending
);
    import rlptx_pkg::*;

    localparam int HDR_MAX = HEADER_MAX_BYTES_DEF;

    typedef struct packed {
        logic [2:0]  field_id;
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic [4:0]  pay_pos;
        logic        done;
        logic [31:0] length;
        logic [31:0] shard;
        status_t     status;
    } parse_report_t;

    parse_report_t parse_reports_q[$];
    parse_report_t fresh;
    parse_report_t want;

    // parser state, mirrors the block
    logic [7:0]  hdr_buf [HDR_MAX];
    int          hdr_fill   = 0;
    logic [3:0]  cur_field  = FLD_ENVELOPE;
    logic        in_body    = 1'b0;
    logic        list_item  = 1'b0;
    logic [31:0] body_len   = '0;
    logic [31:0] body_pos   = '0;
    logic [31:0] shard_acc  = '0;
    logic        sticky_err = 1'b0;

    int fail_cnt = 0;
    int queued   = 0;

    assign mismatches = fail_cnt;
    assign pending    = queued;

    function automatic int unsigned field_limit(input logic [3:0] f);
        if (f == FLD_FROMSHARD || f == FLD_TOSHARD)
            return SHARD_MAX_BYTES_DEF;
        if (f == FLD_DEST)
            return ADDR_MAX_BYTES_DEF;
        return INT_MAX_BYTES_DEF;
    endfunction

    function automatic void clear_parse();
        hdr_fill   = 0;
        cur_field  = FLD_ENVELOPE;
        in_body    = 1'b0;
        list_item  = 1'b0;
        body_len   = '0;
        body_pos   = '0;
        shard_acc  = '0;
        sticky_err = 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic restart,
                               output parse_report_t r);
        logic [7:0]  b0;
        int unsigned nlen;
        logic        self_enc;
        logic        payload;
        logic        bad;

        if (restart)
            clear_parse();
        r = '0;
        r.field_id = (cur_field > FLD_AMOUNT) ? FLD_AMOUNT[2:0] : cur_field[2:0];
        r.status   = ST_MORE;
        if (sticky_err) begin
            r.status = ST_ERR;
            return;
        end
        if (cur_field >= FLD_END) begin
            r.status = ST_DONE;
            return;
        end

        payload  = in_body;
        bad      = 1'b0;
        self_enc = 1'b0;
        if (!in_body) begin
            if (hdr_fill < HDR_MAX) begin
                hdr_buf[hdr_fill] = b;
                hdr_fill++;
            end
            b0   = hdr_buf[0];
            nlen = 0;
            if (b0 > HDR_SSTR_MAX && b0 <= HDR_LSTR_MAX)
                nlen = b0 - HDR_SSTR_MAX;
            else if (b0 > HDR_SLIST_MAX)
                nlen = b0 - HDR_SLIST_MAX;

            if (hdr_fill < nlen + 1) begin
                // header still open; overlong ones fail once the buffer is full
                if (hdr_fill < HDR_MAX)
                    return;
                bad = 1'b1;
            end else if (nlen > LEN_BYTES_MAX) begin
                bad = 1'b1;
            end else begin
                if (b0 <= HDR_SELF_MAX) begin
                    body_len  = 1;
                    list_item = 1'b0;
                    self_enc  = 1'b1;
                end else if (b0 <= HDR_SSTR_MAX) begin
                    body_len  = b0 - HDR_STR_BASE;
                    list_item = 1'b0;
                end else if (b0 <= HDR_LSTR_MAX || b0 > HDR_SLIST_MAX) begin
                    body_len = '0;
                    for (int i = 1; i <= nlen; i++)
                        body_len = {body_len[23:0], hdr_buf[i]};
                    list_item = (b0 > HDR_SLIST_MAX);
                end else begin
                    body_len  = b0 - HDR_LIST_BASE;
                    list_item = 1'b1;
                end
                hdr_fill  = 0;
                body_pos  = '0;
                shard_acc = '0;
                in_body   = 1'b1;

                if (cur_field == FLD_ENVELOPE) begin
                    if (!list_item) begin
                        bad = 1'b1;
                    end else begin
                        // envelope body is not tracked, next header follows
                        r.done   = 1'b1;
                        r.length = body_len;
                        cur_field++;
                        in_body  = 1'b0;
                        return;
                    end
                end else if (list_item || body_len > field_limit(cur_field)) begin
                    bad = 1'b1;
                end
                payload = self_enc;
            end

            if (bad) begin
                sticky_err = 1'b1;
                in_body    = 1'b0;
                hdr_fill   = 0;
                r.status   = ST_ERR;
                return;
            end
        end

        if (payload) begin
            r.pay_valid = 1'b1;
            r.pay_byte  = b;
            r.pay_pos   = body_pos[4:0];
            shard_acc   = {shard_acc[23:0], b};
            body_pos++;
        end
        r.length = body_len;
        if (body_pos >= body_len) begin
            r.done = 1'b1;
            if (cur_field == FLD_FROMSHARD || cur_field == FLD_TOSHARD)
                r.shard = shard_acc;
            cur_field++;
            in_body = 1'b0;
            if (cur_field >= FLD_END)
                r.status = ST_DONE;
        end
    endtask

    task automatic compare_part(input string part, input logic [31:0] exp_v,
                                input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            fail_cnt++;
            $display("%0t: %s expected %0h, got %0h", $time, part, exp_v, got_v);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser[0], fresh);
                parse_reports_q.push_back(fresh);
            end
            if (m_tvalid && m_tready) begin
                if (parse_reports_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: transfer expected none, got user %0h data %0h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = parse_reports_q.pop_front();
                    compare_part("field_id",      32'(want.field_id),  32'(m_tuser[2:0]));
                    compare_part("payload_valid", 32'(want.pay_valid), 32'(m_tdata[0]));
                    compare_part("payload_byte",  32'(want.pay_byte),  32'(m_tdata[8:1]));
                    compare_part("payload_pos",   32'(want.pay_pos),   32'(m_tdata[13:9]));
                    compare_part("field_done",    32'(want.done),      32'(m_tdata[14]));
                    compare_part("field_length",  want.length,         m_tdata[46:15]);
                    compare_part("shard_value",   want.shard,          m_tdata[78:47]);
                    compare_part("status",        32'(want.status),    32'(m_tdata[80:79]));
                    compare_part("pad",           32'd0,               32'(m_tdata[87:81]));
                end
            end
        end
        queued <= parse_reports_q.size();
    end

endmodule

// ===== test/rlp_transaction_field_parser_tb.sv =====
module rlp_transaction_field_parser_tb;

    import rlptx_pkg::*;

    localparam int SHORT_MAX = HDR_SSTR_MAX - HDR_STR_BASE;
    localparam int BYTE_GOAL = 1200;

    typedef enum int {
        FLAW_NONE,
        FLAW_OVERSIZE,
        FLAW_WRONG_KIND,
        FLAW_WIDE_LEN,
        FLAW_CUT,
        FLAW_SPLICE,
        FLAW_NOISE
    } flaw_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;  // data_byte[7:0]
    logic [IN_USER_W-1:0]  s_tuser  = '0;  // start_tx[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // payload_valid[0], payload_byte[8:1], payload_pos[13:9], field_done[14],
    // field_length[46:15], shard_value[78:47], status[80:79], zero[87:81]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;        // field_id[2:0]

    int         mismatch_total;
    int         reports_pending;
    logic [7:0] tx_q[$];
    int         stream_bytes = 0;
    bit         steady_feed  = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rlp_transaction_field_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rlp_field_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatch_total),
        .pending    (reports_pending)
    );

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin : sink_stalls
        int stall;
        forever begin
            m_tready <= 1'b1;
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 6))
                @(posedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic restart);
        int gap;
        gap = steady_feed ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tuser[0] <= restart;
        do @(posedge clk); while (!s_tready);
    endtask

    // first byte opens a new transaction; noisy streams restart at random too
    task automatic send_tx(input bit noisy);
        steady_feed = ($urandom_range(0, 3) == 0);
        foreach (tx_q[i])
            send_byte(tx_q[i], (i == 0) || (noisy && $urandom_range(0, 99) == 0));
        tx_q.delete();
    endtask

    task automatic put_len_header(input logic [7:0] short_base, input logic [7:0] long_base,
                                  input logic [31:0] len, input bit force_long);
        int lo;
        int nl;
        if (len <= SHORT_MAX && !force_long) begin
            tx_q.push_back(short_base + len[7:0]);
            return;
        end
        lo = (len > 32'hffffff) ? 4 : (len > 32'hffff) ? 3 : (len > 32'hff) ? 2 : 1;
        nl = $urandom_range(lo, LEN_BYTES_MAX);   // leading zero bytes allowed
        tx_q.push_back(long_base + 8'(nl));
        for (int i = nl - 1; i >= 0; i--)
            tx_q.push_back(len[8*i +: 8]);
    endtask

    task automatic put_string(input int len);
        logic [7:0] v;
        v = 8'($urandom);
        if (len == 1 && v <= HDR_SELF_MAX && $urandom_range(0, 2) != 0) begin
            tx_q.push_back(v);
            return;
        end
        put_len_header(HDR_STR_BASE, HDR_SSTR_MAX, len, $urandom_range(0, 4) == 0);
        repeat (len) tx_q.push_back(8'($urandom));
    endtask

    function automatic int pick_len(input int f);
        int r;
        r = $urandom_range(0, 99);
        if (f == FLD_FROMSHARD || f == FLD_TOSHARD)
            return $urandom_range(0, SHARD_MAX_BYTES_DEF);
        if (f == FLD_DEST)
            return (r < 70) ? ADDR_MAX_BYTES_DEF : $urandom_range(0, ADDR_MAX_BYTES_DEF);
        if (r < 25)
            return 1;
        if (r < 80)
            return $urandom_range(0, 8);
        return $urandom_range(9, INT_MAX_BYTES_DEF);
    endfunction

    task automatic put_flawed_header(input flaw_t flaw, input int f);
        int lim;
        lim = (f == FLD_FROMSHARD || f == FLD_TOSHARD) ? SHARD_MAX_BYTES_DEF :
              (f == FLD_DEST) ? ADDR_MAX_BYTES_DEF : INT_MAX_BYTES_DEF;
        case (flaw)
            FLAW_OVERSIZE:
                if (f == FLD_ENVELOPE)
                    put_string($urandom_range(0, 3));
                else
                    put_len_header(HDR_STR_BASE, HDR_SSTR_MAX,
                                   ($urandom_range(0, 1) != 0) ? lim + $urandom_range(1, 8)
                                       : lim + 1 + $urandom_range(0, 32'hfffff),
                                   $urandom_range(0, 3) == 0);
            FLAW_WRONG_KIND:
                if (f == FLD_ENVELOPE)
                    put_string($urandom_range(0, 3));
                else
                    put_len_header(HDR_LIST_BASE, HDR_SLIST_MAX, $urandom_range(0, 40),
                                   $urandom_range(0, 3) == 0);
            default:
                // five to eight length bytes
                tx_q.push_back((($urandom_range(0, 1) != 0) ? HDR_SSTR_MAX : HDR_SLIST_MAX)
                               + 8'($urandom_range(5, 8)));
        endcase
        repeat ($urandom_range(0, 6)) tx_q.push_back(8'($urandom));
    endtask

    task automatic build_tx();
        flaw_t flaw;
        int    bad_at;
        int    keep;
        flaw   = ($urandom_range(0, 99) < 75) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
        bad_at = $urandom_range(0, FLD_END - 1);
        if (flaw == FLAW_NOISE) begin
            repeat ($urandom_range(4, 20)) tx_q.push_back(8'($urandom));
        end else begin
            for (int f = 0; f < FLD_END; f++) begin
                if (f == bad_at && (flaw == FLAW_OVERSIZE || flaw == FLAW_WRONG_KIND ||
                                    flaw == FLAW_WIDE_LEN)) begin
                    put_flawed_header(flaw, f);
                    break;
                end
                if (f == FLD_ENVELOPE)
                    put_len_header(HDR_LIST_BASE, HDR_SLIST_MAX,
                                   ($urandom_range(0, 1) != 0) ? $urandom_range(0, SHORT_MAX)
                                                               : $urandom,
                                   $urandom_range(0, 3) == 0);
                else
                    put_string(pick_len(f));
            end
            if (flaw == FLAW_CUT) begin
                keep = $urandom_range(1, tx_q.size());
                while (tx_q.size() > keep)
                    void'(tx_q.pop_back());
            end
            if (flaw == FLAW_SPLICE)
                tx_q[$urandom_range(0, tx_q.size() - 1)] = 8'($urandom);
        end
        stream_bytes += tx_q.size();
        // bytes past the end are ignored by the block
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) tx_q.push_back(8'($urandom));
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full transaction: empty envelope, self-encoded 0x00, empty string,
        // self-encoded 0x7f, 4-byte shard of all ones, long-form shard, empty
        // destination, amount 0xff, then one byte after completion
        tx_q = '{8'hc0, 8'h00, 8'h80, 8'h7f, 8'h84, 8'hff, 8'hff, 8'hff, 8'hff,
                 8'hb8, 8'h01, 8'h00, 8'h80, 8'h81, 8'hff, 8'h5a};
        send_tx(1'b0);
        // max long envelope, then a list where the nonce belongs
        tx_q = '{8'hfb, 8'hff, 8'hff, 8'hff, 8'hff, 8'hc1};
        send_tx(1'b0);
        // eight length bytes overflow the header buffer
        tx_q = '{8'hff, 8'h01, 8'h02, 8'h03, 8'h04};
        send_tx(1'b0);
        // string where the envelope belongs
        tx_q = '{8'h80};
        send_tx(1'b0);

        while (stream_bytes < BYTE_GOAL) begin
            build_tx();
            send_tx(1'b1);
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (reports_pending != 0);
        repeat (5) @(posedge clk);
        if (mismatch_total == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
